@@ rtl/core/sqmae_pkg.sv @@
// shared types and constants of the square matrix arithmetic engine
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package sqmae_pkg;

  // fixed field widths of the channels
  localparam int ELEMENT_W = 16;
  localparam int VALUE_W   = 36;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SCALAR_W  = 16;
  localparam int PROD_W    = 32;

  // operation codes, code 7 acts as transpose
  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_SUB       = 3'd1,
    OP_MUL       = 3'd2,
    OP_SADD      = 3'd3,
    OP_SSUB      = 3'd4,
    OP_SMUL      = 3'd5,
    OP_TRANSPOSE = 3'd6
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPERATION = 2'd0,
    CFG_DIM       = 2'd1,
    CFG_SCALAR    = 2'd2
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_LOAD  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_WAIT  = 2'd2
  } state_e;

endpackage

@@ rtl/core/sqmae_ifs.sv @@
// channel interfaces of the square matrix arithmetic engine
// depends on sqmae_pkg for the field widths
`timescale 1ns / 1ps

interface sqmae_elem_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sqmae_pkg::ELEMENT_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface sqmae_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [sqmae_pkg::VALUE_W-1:0] value;
  logic [sqmae_pkg::IDX_W-1:0]          out_row;
  logic [sqmae_pkg::IDX_W-1:0]          out_col;
  logic                                final_res;

  modport source (output valid, output value, output out_row, output out_col,
                  output final_res, input ready);
  modport sink   (input valid, input value, input out_row, input out_col,
                  input final_res, output ready);
endinterface

interface sqmae_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sqmae_pkg::CFG_IDX_W-1:0]      index;
  logic [sqmae_pkg::CFG_DATA_W-1:0]     wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/core/square_matrix_arithmetic_engine.sv @@
// top level of the square matrix arithmetic engine
// depends on sqmae_pkg and the channel interfaces in sqmae_ifs.sv
`timescale 1ns / 1ps

// usage
// - elem_i takes matrix elements row-major, one transfer per cycle: matrix A,
//   then matrix B for add, subtract and multiply; A only for scalar ops and
//   transpose. matrix size n comes from the dimension register (0 reads as 1,
//   values above MAX_DIM read as MAX_DIM)
// - cfg_i writes operation (0), dimension (1) and scalar (2); always ready.
//   a write to a known register restarts loading, stored elements stay.
//   writes must be made only while the engine is idle; it does not enforce this
// - res_o delivers n*n results row-major with row, column and a final flag
// - after the last element transfer, results are computed one at a time; for
//   each, k store read pairs are issued, k being n for matrix multiply (one
//   multiply-accumulate per cycle, one read port per store) and 1 otherwise,
//   then the read, term, accumulator and done registers lead to the output
// - elem_i is not ready while results are computed; it is ready again as
//   soon as the last result sits in the output register
// - a stalled res_o holds the result register and the sequencer waits
// - reset clears the sequencer and registers (operation add, dimension 8,
//   scalar 0); the element stores are not cleared and read only entries
//   written in the same pass
module square_matrix_arithmetic_engine #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sqmae_elem_if.sink          elem_i,
  sqmae_cfg_if.sink           cfg_i,
  sqmae_res_if.source         res_o
);

  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int VAL_W     = sqmae_pkg::VALUE_W;
  localparam int OUT_IDX_W = sqmae_pkg::IDX_W;
  localparam int SC_W      = sqmae_pkg::SCALAR_W;
  localparam int PROD_W    = sqmae_pkg::PROD_W;

  // configuration registers
  sqmae_pkg::op_e          op_q;
  logic [3:0]              dim_q;
  logic signed [SC_W-1:0]  scalar_q;

  // sequencer
  sqmae_pkg::state_e state_q, state_d;
  logic [IW-1:0] lrow_q, lrow_d, lcol_q, lcol_d;
  logic          second_q, second_d;
  logic [IW-1:0] r_q, r_d, c_q, c_d, k_q, k_d;

  // element stores, read data registered
  logic signed [ELEM_WIDTH-1:0] store_a [DEPTH];
  logic signed [ELEM_WIDTH-1:0] store_b [DEPTH];
  logic signed [ELEM_WIDTH-1:0] rd_a_q, rd_b_q;

  // compute pipeline
  logic                    s1_vld_q, s1_first_q, s1_last_q;
  logic                    s2_vld_q, s2_first_q, s2_last_q;
  logic signed [VAL_W-1:0] term_q, term_d;
  logic signed [VAL_W-1:0] acc_q;
  logic                    acc_done_q;

  // output register
  logic                        out_vld_q;
  logic signed [VAL_W-1:0]     out_value_q;
  logic [OUT_IDX_W-1:0]        out_row_q, out_col_q;
  logic                        out_final_q;

  logic          in_fire, cfg_fire, cfg_hit, out_free;
  logic          issue, push;
  logic [IW-1:0] last_idx;
  logic          is_mul, needs_b, k_last, row_last, col_last;
  logic [AW-1:0] waddr, raddr_a, raddr_b;

  // effective dimension minus one
  always_comb begin
    if (dim_q == 4'd0) begin
      last_idx = '0;
    end else if (dim_q > 4'(MAX_DIM)) begin
      last_idx = IW'(MAX_DIM - 1);
    end else begin
      last_idx = IW'(dim_q - 4'd1);
    end
  end

  assign in_fire  = elem_i.valid && elem_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign cfg_hit  = cfg_fire && (cfg_i.index == sqmae_pkg::CFG_OPERATION ||
                                 cfg_i.index == sqmae_pkg::CFG_DIM ||
                                 cfg_i.index == sqmae_pkg::CFG_SCALAR);
  assign out_free = !out_vld_q || res_o.ready;

  assign is_mul   = (op_q == sqmae_pkg::OP_MUL);
  assign needs_b  = (op_q <= sqmae_pkg::OP_MUL);
  assign k_last   = is_mul ? (k_q == last_idx) : 1'b1;
  assign row_last = (r_q == last_idx);
  assign col_last = (c_q == last_idx);

  assign elem_i.ready = (state_q == sqmae_pkg::ST_LOAD);
  assign cfg_i.ready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= sqmae_pkg::OP_ADD;
      dim_q    <= 4'd8;
      scalar_q <= '0;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        sqmae_pkg::CFG_OPERATION: op_q     <= sqmae_pkg::op_e'(cfg_i.wdata[2:0]);
        sqmae_pkg::CFG_DIM:       dim_q    <= cfg_i.wdata[3:0];
        sqmae_pkg::CFG_SCALAR:    scalar_q <= SC_W'(cfg_i.wdata);
        default: ;
      endcase
    end
  end

  // sequencer: load counters, result walk, multiply-accumulate index
  always_comb begin
    state_d  = state_q;
    lrow_d   = lrow_q;
    lcol_d   = lcol_q;
    second_d = second_q;
    r_d      = r_q;
    c_d      = c_q;
    k_d      = k_q;
    issue    = 1'b0;
    push     = 1'b0;
    case (state_q)
      sqmae_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (lcol_q == last_idx) begin
            lcol_d = '0;
            if (lrow_q == last_idx) begin
              lrow_d = '0;
              // matrix complete: go on with B, or start computing
              if (!second_q && needs_b) begin
                second_d = 1'b1;
              end else begin
                second_d = 1'b0;
                state_d  = sqmae_pkg::ST_ISSUE;
                r_d      = '0;
                c_d      = '0;
                k_d      = '0;
              end
            end else begin
              lrow_d = lrow_q + 1'b1;
            end
          end else begin
            lcol_d = lcol_q + 1'b1;
          end
        end
      end
      sqmae_pkg::ST_ISSUE: begin
        // one store read pair per cycle
        issue = 1'b1;
        if (k_last) begin
          k_d     = '0;
          state_d = sqmae_pkg::ST_WAIT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      sqmae_pkg::ST_WAIT: begin
        // accumulator holds the element once the pipeline drains
        if (acc_done_q && out_free) begin
          push = 1'b1;
          if (col_last) begin
            c_d = '0;
            if (row_last) begin
              r_d     = '0;
              state_d = sqmae_pkg::ST_LOAD;
            end else begin
              r_d     = r_q + 1'b1;
              state_d = sqmae_pkg::ST_ISSUE;
            end
          end else begin
            c_d     = c_q + 1'b1;
            state_d = sqmae_pkg::ST_ISSUE;
          end
        end
      end
      default: state_d = sqmae_pkg::ST_LOAD;
    endcase
    // a register write restarts loading
    if (cfg_hit) begin
      state_d  = sqmae_pkg::ST_LOAD;
      lrow_d   = '0;
      lcol_d   = '0;
      second_d = 1'b0;
      r_d      = '0;
      c_d      = '0;
      k_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sqmae_pkg::ST_LOAD;
      lrow_q   <= '0;
      lcol_q   <= '0;
      second_q <= 1'b0;
      r_q      <= '0;
      c_q      <= '0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      lrow_q   <= lrow_d;
      lcol_q   <= lcol_d;
      second_q <= second_d;
      r_q      <= r_d;
      c_q      <= c_d;
      k_q      <= k_d;
    end
  end

  // store addresses, row-major with MAX_DIM stride
  always_comb begin
    waddr = AW'(AW'(lrow_q) * AW'(MAX_DIM) + AW'(lcol_q));
    if (is_mul) begin
      raddr_a = AW'(AW'(r_q) * AW'(MAX_DIM) + AW'(k_q));
      raddr_b = AW'(AW'(k_q) * AW'(MAX_DIM) + AW'(c_q));
    end else if (op_q >= sqmae_pkg::OP_TRANSPOSE) begin
      raddr_a = AW'(AW'(c_q) * AW'(MAX_DIM) + AW'(r_q));
      raddr_b = raddr_a;
    end else begin
      raddr_a = AW'(AW'(r_q) * AW'(MAX_DIM) + AW'(c_q));
      raddr_b = raddr_a;
    end
  end

  // loads finish before the first read is issued, so no forwarding is needed
  always_ff @(posedge clk_i) begin
    if (in_fire && !second_q) begin
      store_a[waddr] <= ELEM_WIDTH'(elem_i.element);
    end
    rd_a_q <= store_a[raddr_a];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && second_q) begin
      store_b[waddr] <= ELEM_WIDTH'(elem_i.element);
    end
    rd_b_q <= store_b[raddr_b];
  end

  // stage 1: one multiplier shared by matrix and scalar multiply
  logic signed [SC_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0]  a_ext, b_ext, s_ext;

  assign mul_a = SC_W'(rd_a_q);
  assign mul_b = is_mul ? SC_W'(rd_b_q) : scalar_q;
  assign prod  = mul_a * mul_b;
  assign a_ext = VAL_W'(rd_a_q);
  assign b_ext = VAL_W'(rd_b_q);
  assign s_ext = VAL_W'(scalar_q);

  always_comb begin
    case (op_q)
      sqmae_pkg::OP_ADD:  term_d = a_ext + b_ext;
      sqmae_pkg::OP_SUB:  term_d = a_ext - b_ext;
      sqmae_pkg::OP_MUL:  term_d = VAL_W'(prod);
      sqmae_pkg::OP_SADD: term_d = a_ext + s_ext;
      sqmae_pkg::OP_SSUB: term_d = a_ext - s_ext;
      sqmae_pkg::OP_SMUL: term_d = VAL_W'(prod);
      default:            term_d = a_ext;
    endcase
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      acc_done_q <= 1'b0;
    end else if (cfg_hit) begin
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (s2_vld_q && s2_last_q) begin
        acc_done_q <= 1'b1;
      end else if (push) begin
        acc_done_q <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    s1_first_q <= (k_q == '0);
    s1_last_q  <= k_last;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    term_q     <= term_d;
    if (s2_vld_q) begin
      acc_q <= s2_first_q ? term_q : acc_q + term_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_value_q <= acc_q;
      out_row_q   <= OUT_IDX_W'(r_q);
      out_col_q   <= OUT_IDX_W'(c_q);
      out_final_q <= row_last && col_last;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.value     = out_value_q;
  assign res_o.out_row   = out_row_q;
  assign res_o.out_col   = out_col_q;
  assign res_o.final_res = out_final_q;

  // checks
  a_load_idle_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sqmae_pkg::ST_LOAD |-> !s1_vld_q && !s2_vld_q)
    else $error("pipeline busy while loading");

  a_issue_no_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sqmae_pkg::ST_ISSUE |-> !acc_done_q)
    else $error("new element issued over a pending result");

  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q && s2_last_q && !cfg_hit |=> acc_done_q)
    else $error("accumulation end not flagged");

  a_final_to_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && row_last && col_last |=> state_q == sqmae_pkg::ST_LOAD)
    else $error("sequencer did not return to loading after last result");

endmodule
